[rtl/lbms_pkg.sv]
package lbms_pkg;

  // Default sizes of the message store and of the time-in-state counter.
  localparam int MESSAGE_DEPTH_DEF = 256;
  localparam int TIME_WIDTH_DEF    = 24;

  // Fixed widths of the configuration registers.
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;
  localparam int TOTAL_W     = 24;
  localparam int PHASE_CNT_W = 16;

  typedef enum logic [1:0] {
    ST_OFF   = 2'd0,
    ST_BLINK = 2'd1,
    ST_ON    = 2'd2,
    ST_MORSE = 2'd3
  } sys_state_t;

  typedef enum logic [2:0] {
    PH_LOAD   = 3'd0,
    PH_LETTER = 3'd1,
    PH_SYMBOL = 3'd2,
    PH_ON     = 3'd3,
    PH_OFF    = 3'd4,
    PH_DONE   = 3'd5
  } seq_phase_t;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_MODE   = 2'd1,
    ACT_APPEND = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Symbol codes as stored in the message.
  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_OTHER = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_DEFAULT_MODE  = 3'd0;
  localparam logic [2:0] REG_BLINK_HALF    = 3'd1;
  localparam logic [2:0] REG_BLINK_TOTAL   = 3'd2;
  localparam logic [2:0] REG_DOT           = 3'd3;
  localparam logic [2:0] REG_DASH          = 3'd4;
  localparam logic [2:0] REG_LETTER_PAUSE  = 3'd5;
  localparam logic [2:0] REG_WORD_PAUSE    = 3'd6;

  // Register reset values.
  localparam logic [1:0]  DEFAULT_MODE_RST  = 2'd0;
  localparam logic [15:0] BLINK_HALF_RST    = 16'd10;
  localparam logic [23:0] BLINK_TOTAL_RST   = 24'd100;
  localparam logic [15:0] DOT_RST           = 16'd5;
  localparam logic [15:0] DASH_RST          = 16'd15;
  localparam logic [15:0] LETTER_PAUSE_RST  = 16'd20;
  localparam logic [15:0] WORD_PAUSE_RST    = 16'd50;

endpackage

[rtl/led_blink_and_morse_sequencer.sv]
// A result item appears in the output register in the cycle after its input item.
// One item per cycle unless results stall; the state update is a single registered step.
// A stalled result holds the input side only while the output register stays full.
// Reset (synchronous, active high) clears all control state and restores register defaults.
// The symbol store is not cleared; only entries below the message length are ever read.
module led_blink_and_morse_sequencer
  import lbms_pkg::*;
#(
  parameter int MESSAGE_DEPTH = MESSAGE_DEPTH_DEF,
  parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            action,
  input  logic [1:0]            mode,
  input  logic [1:0]            symbol,
  input  logic                  letter_end,
  // Result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  led_on,
  output logic [1:0]            system_state,
  output logic [2:0]            morse_phase,
  output logic                  write_refused
);

  // Address width of the store and width of a length that can reach the depth.
  localparam int AW = $clog2(MESSAGE_DEPTH);
  localparam int LW = $clog2(MESSAGE_DEPTH + 1);
  // Blink total is compared in a width that holds both the register and the counter.
  localparam int CW = ((TIME_WIDTH > TOTAL_W) ? TIME_WIDTH : TOTAL_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access takes the
  // usual setup and access cycle; reads return the register contents.
  // ---------------------------------------------------------------------------
  logic [1:0]             default_mode;
  logic [PHASE_CNT_W-1:0] blink_half_ticks;
  logic [TOTAL_W-1:0]     blink_total_ticks;
  logic [PHASE_CNT_W-1:0] dot_ticks;
  logic [PHASE_CNT_W-1:0] dash_ticks;
  logic [PHASE_CNT_W-1:0] letter_pause_ticks;
  logic [PHASE_CNT_W-1:0] word_pause_ticks;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_mode       <= DEFAULT_MODE_RST;
      blink_half_ticks   <= BLINK_HALF_RST;
      blink_total_ticks  <= BLINK_TOTAL_RST;
      dot_ticks          <= DOT_RST;
      dash_ticks         <= DASH_RST;
      letter_pause_ticks <= LETTER_PAUSE_RST;
      word_pause_ticks   <= WORD_PAUSE_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_DEFAULT_MODE: default_mode       <= pwdata[1:0];
        REG_BLINK_HALF:   blink_half_ticks   <= pwdata[PHASE_CNT_W-1:0];
        REG_BLINK_TOTAL:  blink_total_ticks  <= pwdata[TOTAL_W-1:0];
        REG_DOT:          dot_ticks          <= pwdata[PHASE_CNT_W-1:0];
        REG_DASH:         dash_ticks         <= pwdata[PHASE_CNT_W-1:0];
        REG_LETTER_PAUSE: letter_pause_ticks <= pwdata[PHASE_CNT_W-1:0];
        REG_WORD_PAUSE:   word_pause_ticks   <= pwdata[PHASE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DEFAULT_MODE: prdata = CFG_DATA_W'(default_mode);
      REG_BLINK_HALF:   prdata = CFG_DATA_W'(blink_half_ticks);
      REG_BLINK_TOTAL:  prdata = CFG_DATA_W'(blink_total_ticks);
      REG_DOT:          prdata = CFG_DATA_W'(dot_ticks);
      REG_DASH:         prdata = CFG_DATA_W'(dash_ticks);
      REG_LETTER_PAUSE: prdata = CFG_DATA_W'(letter_pause_ticks);
      REG_WORD_PAUSE:   prdata = CFG_DATA_W'(word_pause_ticks);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. The output register decouples the two sides: a new item is
  // taken whenever the result register is empty or is being emptied.
  // ---------------------------------------------------------------------------
  logic accept;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // ---------------------------------------------------------------------------
  // Controller state.
  // ---------------------------------------------------------------------------
  sys_state_t             current_state, state_next;
  logic [1:0]             requested_mode, requested_mode_next;
  logic                   led_level, led_level_next;
  logic [TIME_WIDTH-1:0]  ticks_in_state, ticks_in_state_next;
  logic [PHASE_CNT_W-1:0] blink_phase_count, blink_phase_count_next;
  logic                   blink_phase_odd, blink_phase_odd_next;
  seq_phase_t             sequencer_phase, sequencer_phase_next;
  logic [PHASE_CNT_W-1:0] phase_ticks, phase_ticks_next;
  logic [LW-1:0]          message_length, message_length_next;
  logic [LW-1:0]          playback_length, playback_length_next;
  logic [LW-1:0]          read_pointer, read_pointer_next;
  logic                   letter_open, letter_open_next;
  logic [1:0]             current_symbol, current_symbol_next;

  // Message store: three bits per symbol, the letter end mark on top.
  logic [2:0]             symbol_store [MESSAGE_DEPTH];
  logic [2:0]             store_rd_data;
  logic                   store_we;

  // Helpers of the tick step.
  sys_state_t             tick_state;
  logic                   morse_end;
  logic                   refused;
  logic [PHASE_CNT_W-1:0] blink_count_inc;
  logic [PHASE_CNT_W-1:0] symbol_time;
  logic [LW-1:0]          read_pointer_inc;
  logic [CW-1:0]          ticks_ext;
  logic [CW-1:0]          total_ext;
  logic [CW-1:0]          time_max_ext;
  logic [CW-1:0]          total_clamped;

  assign ticks_ext     = CW'(ticks_in_state);
  assign total_ext     = CW'(blink_total_ticks);
  assign time_max_ext  = CW'({TIME_WIDTH{1'b1}});
  // A blink total beyond the counter range is clamped so a saturated counter still expires.
  assign total_clamped = (total_ext < time_max_ext) ? total_ext : time_max_ext;

  assign symbol_time      = (current_symbol == SYM_DOT) ? dot_ticks : dash_ticks;
  assign read_pointer_inc = read_pointer + LW'(1);

  // Next-state logic. Only a tick advances time; the other actions touch the
  // requested mode or the message store.
  always_comb begin
    state_next             = current_state;
    requested_mode_next    = requested_mode;
    led_level_next         = led_level;
    ticks_in_state_next    = ticks_in_state;
    blink_phase_count_next = blink_phase_count;
    blink_phase_odd_next   = blink_phase_odd;
    sequencer_phase_next   = sequencer_phase;
    phase_ticks_next       = phase_ticks;
    message_length_next    = message_length;
    playback_length_next   = playback_length;
    read_pointer_next      = read_pointer;
    letter_open_next       = letter_open;
    current_symbol_next    = current_symbol;
    tick_state             = current_state;
    morse_end              = 1'b0;
    refused                = 1'b0;
    store_we               = 1'b0;
    blink_count_inc        = blink_phase_count + PHASE_CNT_W'(1);

    if (accept) begin
      case (action)
        ACT_TICK: begin
          // The time-in-state counter saturates; comparisons use the old value.
          if (ticks_in_state != {TIME_WIDTH{1'b1}}) begin
            ticks_in_state_next = ticks_in_state + TIME_WIDTH'(1);
          end
          case (current_state)
            ST_BLINK: begin
              if (ticks_ext >= total_clamped) begin
                requested_mode_next = default_mode;
                led_level_next      = 1'b0;
                tick_state          = ST_OFF;
              end else begin
                // A half period of zero acts as one: the compare always fires.
                if (blink_count_inc >= blink_half_ticks) begin
                  blink_phase_count_next = '0;
                  blink_phase_odd_next   = ~blink_phase_odd;
                end else begin
                  blink_phase_count_next = blink_count_inc;
                end
                led_level_next = ~blink_phase_odd_next;
                tick_state     = ST_BLINK;
              end
            end
            ST_ON: begin
              led_level_next = 1'b1;
              tick_state     = sys_state_t'(requested_mode);
            end
            ST_MORSE: begin
              tick_state = ST_MORSE;
              if (phase_ticks != {PHASE_CNT_W{1'b1}}) begin
                phase_ticks_next = phase_ticks + PHASE_CNT_W'(1);
              end
              case (sequencer_phase)
                PH_LOAD: begin
                  if (message_length == '0) begin
                    morse_end = 1'b1;
                  end else begin
                    playback_length_next = message_length;
                    read_pointer_next    = '0;
                    led_level_next       = 1'b0;
                    sequencer_phase_next = PH_LETTER;
                  end
                end
                PH_LETTER: begin
                  if (read_pointer < playback_length) begin
                    letter_open_next     = 1'b1;
                    sequencer_phase_next = PH_SYMBOL;
                  end else begin
                    sequencer_phase_next = PH_DONE;
                    phase_ticks_next     = '0;
                  end
                end
                PH_SYMBOL: begin
                  if (letter_open && (read_pointer < playback_length)) begin
                    // The store output already holds the entry at read_pointer.
                    read_pointer_next    = read_pointer_inc;
                    current_symbol_next  = store_rd_data[1:0];
                    letter_open_next     = ~store_rd_data[2] &
                                           (read_pointer_inc < playback_length);
                    sequencer_phase_next = PH_ON;
                    phase_ticks_next     = '0;
                  end else begin
                    letter_open_next = 1'b0;
                    if (phase_ticks >= letter_pause_ticks) begin
                      sequencer_phase_next = PH_LETTER;
                    end
                  end
                end
                PH_ON: begin
                  if (current_symbol <= SYM_DASH) begin
                    led_level_next = 1'b1;
                    if (phase_ticks >= symbol_time) begin
                      sequencer_phase_next = PH_OFF;
                      phase_ticks_next     = '0;
                    end
                  end else begin
                    sequencer_phase_next = PH_SYMBOL;
                  end
                end
                PH_OFF: begin
                  if (current_symbol <= SYM_DASH) begin
                    led_level_next = 1'b0;
                    if (phase_ticks >= symbol_time) begin
                      sequencer_phase_next = PH_SYMBOL;
                      current_symbol_next  = SYM_OTHER;
                      phase_ticks_next     = '0;
                    end
                  end else begin
                    sequencer_phase_next = PH_SYMBOL;
                  end
                end
                PH_DONE: begin
                  if (phase_ticks >= word_pause_ticks) begin
                    morse_end = 1'b1;
                  end
                end
                default: morse_end = 1'b1;
              endcase
              if (morse_end) begin
                sequencer_phase_next = PH_LOAD;
                phase_ticks_next     = '0;
                current_symbol_next  = SYM_OTHER;
                requested_mode_next  = default_mode;
                led_level_next       = 1'b0;
                tick_state           = ST_OFF;
              end
            end
            default: begin
              led_level_next = 1'b0;
              tick_state     = sys_state_t'(requested_mode);
            end
          endcase
          // Any change of system state restarts the state timers.
          if (tick_state != current_state) begin
            state_next             = tick_state;
            ticks_in_state_next    = '0;
            blink_phase_count_next = '0;
            blink_phase_odd_next   = 1'b0;
          end
        end
        ACT_MODE: begin
          requested_mode_next = mode;
        end
        ACT_APPEND: begin
          if ((current_state == ST_MORSE) || (message_length >= LW'(MESSAGE_DEPTH))) begin
            refused = 1'b1;
          end else begin
            store_we            = 1'b1;
            message_length_next = message_length + LW'(1);
          end
        end
        default: begin
          if (current_state == ST_MORSE) begin
            refused = 1'b1;
          end else begin
            message_length_next = '0;
          end
        end
      endcase
    end
  end

  // Result fields of this item, taken from the updated state.
  logic       res_led;
  logic [1:0] res_state;
  logic [2:0] res_phase;
  logic       res_refused;

  always_comb begin
    res_led     = led_level_next;
    res_state   = state_next;
    res_phase   = sequencer_phase_next;
    res_refused = refused;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state     <= ST_OFF;
      requested_mode    <= ST_OFF;
      led_level         <= 1'b0;
      ticks_in_state    <= '0;
      blink_phase_count <= '0;
      blink_phase_odd   <= 1'b0;
      sequencer_phase   <= PH_LOAD;
      phase_ticks       <= '0;
      message_length    <= '0;
      playback_length   <= '0;
      read_pointer      <= '0;
      letter_open       <= 1'b0;
      current_symbol    <= SYM_OTHER;
    end else begin
      current_state     <= state_next;
      requested_mode    <= requested_mode_next;
      led_level         <= led_level_next;
      ticks_in_state    <= ticks_in_state_next;
      blink_phase_count <= blink_phase_count_next;
      blink_phase_odd   <= blink_phase_odd_next;
      sequencer_phase   <= sequencer_phase_next;
      phase_ticks       <= phase_ticks_next;
      message_length    <= message_length_next;
      playback_length   <= playback_length_next;
      read_pointer      <= read_pointer_next;
      letter_open       <= letter_open_next;
      current_symbol    <= current_symbol_next;
    end
  end

  // Store with a registered read. The read address follows the next read
  // pointer, so the entry under the pointer is always ready at the symbol
  // step; writes only happen outside playback, so the read never races one.
  always_ff @(posedge clk) begin
    if (store_we) begin
      symbol_store[message_length[AW-1:0]] <= {letter_end, symbol};
    end
    store_rd_data <= symbol_store[read_pointer_next[AW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_on        <= res_led;
      system_state  <= res_state;
      morse_phase   <= res_phase;
      write_refused <= res_refused;
    end
  end

`ifndef SYNTHESIS
  // The sequencer rests at its load step whenever playback is not running.
  assert property (@(posedge clk) disable iff (rst)
    (current_state != ST_MORSE) |-> (sequencer_phase == PH_LOAD))
    else $error("sequencer left its load step outside playback");

  // The message cannot change while it is being played.
  assert property (@(posedge clk) disable iff (rst)
    (current_state == ST_MORSE) |=> $stable(message_length))
    else $error("message length changed during playback");

  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst)
    message_length <= LW'(MESSAGE_DEPTH))
    else $error("message length beyond store depth");

  // The read pointer never runs past the snapshot length.
  assert property (@(posedge clk) disable iff (rst)
    read_pointer <= playback_length)
    else $error("read pointer beyond playback length");

  // Every accepted item leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");
`endif

endmodule

[dv/led_status_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration port and both item channels of the LED sequencer.
// It keeps its own copy of the block state, predicts one status item per
// accepted input item, and compares each accepted result with the oldest
// prediction.
module led_status_checker
  import lbms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  logic [1:0]            action,
  input  logic [1:0]            mode,
  input  logic [1:0]            symbol,
  input  logic                  letter_end,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic                  led_on,
  input  logic [1:0]            system_state,
  input  logic [2:0]            morse_phase,
  input  logic                  write_refused,
  output int                    mismatch_count,
  output int                    pending_count
);

  localparam int MSG_DEPTH = MESSAGE_DEPTH_DEF;
  localparam int MSG_AW    = $clog2(MSG_DEPTH);
  localparam int TIME_W    = TIME_WIDTH_DEF;
  localparam logic [TIME_W-1:0] TIME_SAT = '1;
  localparam logic [15:0] PHASE_SAT = '1;

  typedef struct packed {
    logic       led;
    sys_state_t state;
    seq_phase_t phase;
    logic       refused;
  } led_status_t;

  // Register copies.
  logic [1:0]  cfg_default;
  logic [15:0] cfg_half;
  logic [23:0] cfg_total;
  logic [15:0] cfg_dot;
  logic [15:0] cfg_dash;
  logic [15:0] cfg_letter;
  logic [15:0] cfg_word;

  // Predicted block state.
  sys_state_t        cur_state;
  logic [1:0]        req_mode;
  logic              led_lvl;
  logic [TIME_W-1:0] state_ticks;
  logic [15:0]       half_count;
  logic              half_odd;
  seq_phase_t        seq_ph;
  logic [15:0]       ph_ticks;
  logic [2:0]        msg_store [MSG_DEPTH];
  logic [8:0]        msg_len;
  logic [8:0]        play_len;
  logic [8:0]        rd_ptr;
  logic              letter_open_q;
  logic [1:0]        cur_sym;

  led_status_t expected_status [$];
  led_status_t want_st;
  led_status_t got_st;
  int          fail_tally = 0;

  assign mismatch_count = fail_tally;

  function automatic void reset_prediction();
    cfg_default   = DEFAULT_MODE_RST;
    cfg_half      = BLINK_HALF_RST;
    cfg_total     = BLINK_TOTAL_RST;
    cfg_dot       = DOT_RST;
    cfg_dash      = DASH_RST;
    cfg_letter    = LETTER_PAUSE_RST;
    cfg_word      = WORD_PAUSE_RST;
    cur_state     = ST_OFF;
    req_mode      = 2'd0;
    led_lvl       = 1'b0;
    state_ticks   = '0;
    half_count    = '0;
    half_odd      = 1'b0;
    seq_ph        = PH_LOAD;
    ph_ticks      = '0;
    msg_len       = '0;
    play_len      = '0;
    rd_ptr        = '0;
    letter_open_q = 1'b0;
    cur_sym       = SYM_OTHER;
  endfunction

  // Leaving playback always lands in off and re-arms the default request.
  function automatic sys_state_t morse_finish();
    seq_ph   = PH_LOAD;
    ph_ticks = '0;
    cur_sym  = SYM_OTHER;
    req_mode = cfg_default;
    led_lvl  = 1'b0;
    return ST_OFF;
  endfunction

  function automatic logic [15:0] symbol_span();
    return (cur_sym == SYM_DOT) ? cfg_dot : cfg_dash;
  endfunction

  // One tick of the Morse sequencer; thresholds compare the count before the
  // increment, so a saturated phase counter still expires.
  function automatic sys_state_t morse_step();
    logic [15:0] prior;
    logic [2:0]  entry;
    sys_state_t  nxt;
    prior = ph_ticks;
    nxt   = ST_MORSE;
    if (ph_ticks != PHASE_SAT) ph_ticks++;
    case (seq_ph)
      PH_LOAD: begin
        if (msg_len == 0) begin
          nxt = morse_finish();
        end else begin
          play_len = msg_len;
          rd_ptr   = '0;
          led_lvl  = 1'b0;
          seq_ph   = PH_LETTER;
        end
      end
      PH_LETTER: begin
        if (rd_ptr < play_len) begin
          letter_open_q = 1'b1;
          seq_ph        = PH_SYMBOL;
        end else begin
          seq_ph   = PH_DONE;
          ph_ticks = '0;
        end
      end
      PH_SYMBOL: begin
        if (letter_open_q && rd_ptr < play_len) begin
          entry         = msg_store[rd_ptr[MSG_AW-1:0]];
          rd_ptr++;
          cur_sym       = entry[1:0];
          letter_open_q = !entry[2] && (rd_ptr < play_len);
          seq_ph        = PH_ON;
          ph_ticks      = '0;
        end else begin
          letter_open_q = 1'b0;
          if (prior >= cfg_letter) seq_ph = PH_LETTER;
        end
      end
      PH_ON: begin
        if (cur_sym <= SYM_DASH) begin
          led_lvl = 1'b1;
          if (prior >= symbol_span()) begin
            seq_ph   = PH_OFF;
            ph_ticks = '0;
          end
        end else begin
          seq_ph = PH_SYMBOL;
        end
      end
      PH_OFF: begin
        if (cur_sym <= SYM_DASH) begin
          led_lvl = 1'b0;
          if (prior >= symbol_span()) begin
            seq_ph   = PH_SYMBOL;
            cur_sym  = SYM_OTHER;
            ph_ticks = '0;
          end
        end else begin
          seq_ph = PH_SYMBOL;
        end
      end
      PH_DONE: begin
        if (prior >= cfg_word) nxt = morse_finish();
      end
      default: nxt = morse_finish();
    endcase
    return nxt;
  endfunction

  function automatic void loop_tick();
    logic [TIME_W-1:0] prior;
    sys_state_t        nxt;
    prior = state_ticks;
    if (state_ticks != TIME_SAT) state_ticks++;
    case (cur_state)
      ST_BLINK: begin
        if (prior >= cfg_total) begin
          req_mode = cfg_default;
          led_lvl  = 1'b0;
          nxt      = ST_OFF;
        end else begin
          half_count++;
          // A half period of zero toggles on every tick, like a half of one.
          if (half_count >= cfg_half) begin
            half_count = '0;
            half_odd   = !half_odd;
          end
          led_lvl = !half_odd;
          nxt     = ST_BLINK;
        end
      end
      ST_ON: begin
        led_lvl = 1'b1;
        nxt     = sys_state_t'(req_mode);
      end
      ST_MORSE: nxt = morse_step();
      default: begin
        led_lvl = 1'b0;
        nxt     = sys_state_t'(req_mode);
      end
    endcase
    if (nxt != cur_state) begin
      cur_state   = nxt;
      state_ticks = '0;
      half_count  = '0;
      half_odd    = 1'b0;
    end
  endfunction

  function automatic led_status_t apply_led_item(action_t act, logic [1:0] md,
                                                 logic [1:0] sym, logic lend);
    logic refused;
    refused = 1'b0;
    case (act)
      ACT_TICK: loop_tick();
      ACT_MODE: req_mode = md;
      ACT_APPEND: begin
        if (cur_state == ST_MORSE || msg_len >= MSG_DEPTH) begin
          refused = 1'b1;
        end else begin
          msg_store[msg_len[MSG_AW-1:0]] = {lend, sym};
          msg_len++;
        end
      end
      default: begin
        if (cur_state == ST_MORSE) refused = 1'b1;
        else msg_len = '0;
      end
    endcase
    return '{led_lvl, cur_state, seq_ph, refused};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_prediction();
      expected_status.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DEFAULT_MODE: cfg_default = pwdata[1:0];
          REG_BLINK_HALF:   cfg_half    = pwdata[15:0];
          REG_BLINK_TOTAL:  cfg_total   = pwdata[23:0];
          REG_DOT:          cfg_dot     = pwdata[15:0];
          REG_DASH:         cfg_dash    = pwdata[15:0];
          REG_LETTER_PAUSE: cfg_letter  = pwdata[15:0];
          REG_WORD_PAUSE:   cfg_word    = pwdata[15:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall) begin
        got_st = '{led_on, sys_state_t'(system_state), seq_phase_t'(morse_phase),
                   write_refused};
        if (expected_status.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("Unexpected status item: led=%0d state=%0d phase=%0d refused=%0d",
                     got_st.led, got_st.state, got_st.phase, got_st.refused);
        end else begin
          want_st = expected_status[0];
          expected_status.delete(0);
          if (got_st.led !== want_st.led || got_st.state !== want_st.state ||
              got_st.phase !== want_st.phase || got_st.refused !== want_st.refused) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display({"Status mismatch: expected led=%0d state=%0d phase=%0d ",
                        "refused=%0d, got led=%0d state=%0d phase=%0d refused=%0d"},
                       want_st.led, want_st.state, want_st.phase, want_st.refused,
                       got_st.led, got_st.state, got_st.phase, got_st.refused);
          end
        end
      end

      if (item_valid && !item_stall)
        expected_status.push_back(apply_led_item(action_t'(action), mode, symbol,
                                                 letter_end));
    end
    pending_count <= expected_status.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

// Top of the LED sequencer testbench. It makes the clock and the single reset,
// programs the timing registers between phases, offers items and stalls
// results at random, and prints the verdict. All prediction and comparison
// lives in the checker instantiated next to the block.
module testbench;
  import lbms_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [1:0]            action = 2'd0;
  logic [1:0]            mode = 2'd0;
  logic [1:0]            symbol = 2'd0;
  logic                  letter_end = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  led_on;
  logic [1:0]            system_state;
  logic [2:0]            morse_phase;
  logic                  write_refused;

  // Shared between the sender and the receiver: quiet switches off random
  // idling on both sides, hold_request asks the receiver for one long stall.
  logic quiet = 1'b0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int mismatch_count;
  int pending_count;
  int items_sent = 0;
  int cycle_count = 0;

  led_blink_and_morse_sequencer DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .mode         (mode),
    .symbol       (symbol),
    .letter_end   (letter_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .led_on       (led_on),
    .system_state (system_state),
    .morse_phase  (morse_phase),
    .write_refused(write_refused)
  );

  led_status_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .mode          (mode),
    .symbol        (symbol),
    .letter_end    (letter_end),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .led_on        (led_on),
    .system_state  (system_state),
    .morse_phase   (morse_phase),
    .write_refused (write_refused),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  always #2 clk = ~clk;

  // Reset is held at the start of the run and never again.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: a run that hangs on a handshake fails here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side. The long hold-off is counted here, so the sender keeps
  // offering items while the output register stays full and the block has to
  // stall its input.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= 60;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !quiet && ($urandom_range(99) < 12);
    end
  end

  // Offers one item and returns in the time step of the edge that accepted it.
  // Valid stays high from item to item unless a random gap is inserted, and
  // the payload is only changed once the previous item has been taken.
  task automatic offer_item(action_t act, logic [1:0] md, logic [1:0] sym, logic lend);
    if (!quiet && $urandom_range(99) < 12) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    mode       <= md;
    symbol     <= sym;
    letter_end <= lend;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // Setup cycle then access cycle; psel is left high so that back-to-back
  // writes never lower and raise it in the same step.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_timing(logic [1:0] dflt, logic [15:0] half, logic [23:0] total,
                                logic [15:0] dot, logic [15:0] dash, logic [15:0] lpause,
                                logic [15:0] wpause);
    write_reg(REG_DEFAULT_MODE, 32'(dflt));
    write_reg(REG_BLINK_HALF, 32'(half));
    write_reg(REG_BLINK_TOTAL, 32'(total));
    write_reg(REG_DOT, 32'(dot));
    write_reg(REG_DASH, 32'(dash));
    write_reg(REG_LETTER_PAUSE, 32'(lpause));
    write_reg(REG_WORD_PAUSE, 32'(wpause));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering and waits until every predicted status item has been
  // checked. Each item yields exactly one result, so an empty queue means the
  // block is idle; an extra wait afterwards covers the output register.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_start;
    int         budget;
    int         kind;
    int         n;
    int         r;
    logic [1:0] sym;

    do @(posedge clk); while (rst);

    // All timing registers at zero: every dot, dash and pause lasts a single
    // tick, blink toggles on every tick and blink ends right away.
    program_timing(2'd0, 16'd0, 24'd0, 16'd0, 16'd0, 16'd0, 16'd0);

    // Fill the message store from empty; the last two appends find it full
    // and must be refused. Clearing afterwards keeps later messages short.
    offer_item(ACT_CLEAR, 2'd0, 2'd0, 1'b0);
    repeat (MESSAGE_DEPTH_DEF + 2)
      offer_item(ACT_APPEND, 2'($urandom), 2'($urandom), 1'($urandom));
    offer_item(ACT_CLEAR, 2'd0, 2'd0, 1'b0);

    // Directed walk through the modes. Off to fixed on, then blink, which
    // expires at once with a zero total.
    offer_item(ACT_TICK, 2'd3, 2'd3, 1'b1);
    offer_item(ACT_MODE, ST_ON, 2'd0, 1'b0);
    offer_item(ACT_TICK, 2'd0, 2'd0, 1'b0);
    offer_item(ACT_TICK, 2'd0, 2'd0, 1'b0);
    offer_item(ACT_MODE, ST_BLINK, 2'd0, 1'b0);
    offer_item(ACT_TICK, 2'd0, 2'd0, 1'b0);
    offer_item(ACT_TICK, 2'd0, 2'd0, 1'b0);
    // A message with a skipped symbol, a symbol of value three and a final
    // letter that carries no end mark.
    offer_item(ACT_CLEAR, 2'd0, 2'd0, 1'b0);
    offer_item(ACT_APPEND, 2'd0, SYM_DOT, 1'b0);
    offer_item(ACT_APPEND, 2'd0, SYM_DASH, 1'b1);
    offer_item(ACT_APPEND, 2'd0, SYM_OTHER, 1'b0);
    offer_item(ACT_APPEND, 2'd0, 2'd3, 1'b1);
    offer_item(ACT_APPEND, 2'd0, SYM_DASH, 1'b0);
    offer_item(ACT_MODE, ST_MORSE, 2'd0, 1'b0);
    offer_item(ACT_TICK, 2'd0, 2'd0, 1'b0);
    // Writes during playback are refused; a mode request is only stored.
    offer_item(ACT_APPEND, 2'd0, SYM_DOT, 1'b1);
    offer_item(ACT_CLEAR, 2'd0, 2'd0, 1'b0);
    offer_item(ACT_MODE, ST_ON, 2'd0, 1'b0);
    repeat (12) offer_item(ACT_TICK, 2'd0, 2'd0, 1'b0);

    // Random phases, each under its own register setting, until the item
    // target is reached.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      drain_results();
      if (phase == 1) begin
        // Largest values: playback and blink effectively never advance here;
        // the next, faster setting lets them expire.
        program_timing(2'd3, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else if (phase % 4 == 0) begin
        program_timing(DEFAULT_MODE_RST, BLINK_HALF_RST, BLINK_TOTAL_RST, DOT_RST, DASH_RST,
                       LETTER_PAUSE_RST, WORD_PAUSE_RST);
      end else begin
        program_timing(2'($urandom_range(3)), 16'($urandom_range(6)),
                       24'($urandom_range(80)), 16'($urandom_range(4)),
                       16'($urandom_range(8)), 16'($urandom_range(8)),
                       16'($urandom_range(12)));
      end
      budget = (phase == 1) ? 80 : 200;
      quiet <= (phase == 3);
      if (phase == 2) hold_request <= 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < budget) begin
        kind = $urandom_range(9);
        if (kind < 7) begin
          // Well-formed message: optional clear, a few symbols, a request for
          // playback, then a run of ticks with the odd stray item mixed in.
          if ($urandom_range(3) != 0)
            offer_item(ACT_CLEAR, 2'($urandom), 2'($urandom), 1'($urandom));
          n = $urandom_range(6);
          repeat (n) begin
            r   = $urandom_range(19);
            sym = (r < 9) ? SYM_DOT : (r < 18) ? SYM_DASH : 2'(r - 16);
            offer_item(ACT_APPEND, 2'($urandom), sym, $urandom_range(2) == 0);
          end
          offer_item(ACT_MODE, ($urandom_range(7) == 0) ? 2'($urandom) : ST_MORSE,
                     2'($urandom), 1'($urandom));
          n = $urandom_range(80, 10);
          repeat (n) begin
            if ($urandom_range(24) == 0)
              offer_item(action_t'($urandom_range(3)), 2'($urandom), 2'($urandom),
                         1'($urandom));
            else
              offer_item(ACT_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
          end
        end else if (kind < 9) begin
          // Steady modes: off, blink or fixed on, followed by ticks.
          offer_item(ACT_MODE, 2'($urandom_range(2)), 2'($urandom), 1'($urandom));
          n = $urandom_range(60, 5);
          repeat (n) offer_item(ACT_TICK, 2'($urandom), 2'($urandom), 1'($urandom));
        end else begin
          // Unstructured items.
          repeat (8)
            offer_item(action_t'($urandom_range(3)), 2'($urandom), 2'($urandom),
                       1'($urandom));
        end
      end
      quiet <= 1'b0;
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
